// File: rtl/transverse_mass_calc_macros.svh
// Assertion macros shared by the transverse mass checker.
`ifndef TRANSVERSE_MASS_CALC_MACROS_SVH
`define TRANSVERSE_MASS_CALC_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define TMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tmc_pkg.sv
// Package with the constants and the cosine table generator of the transverse mass block.
package tmc_pkg;

	localparam int DEF_ANGLE_BITS    = 10;
	localparam int DEF_MOMENTUM_BITS = 16;
	localparam int Q_BITS            = 30;
	localparam int G_W               = 32;

	localparam longint unsigned ONE_Q30 = 64'd1 << Q_BITS;
	localparam longint unsigned PI_Q30  = 64'd3373259426;

	function automatic longint unsigned mul_q30(input longint unsigned x2, input longint t);
		longint unsigned tt;
		tt = (t < 0) ? 64'd0 : longint'(t);
		return (x2 * tt) >> Q_BITS;
	endfunction

	function automatic longint cos_q30(input int angle_bits, input int a);
		longint unsigned x;
		longint unsigned x2;
		longint t;
		x  = (longint'(a) * (2 * PI_Q30) + (64'd1 << (angle_bits - 1))) >> angle_bits;
		x2 = (x * x) >> Q_BITS;
		t  = longint'(ONE_Q30);
		t  = longint'(ONE_Q30) - longint'(mul_q30(x2, t)) / 182;
		t  = longint'(ONE_Q30) - longint'(mul_q30(x2, t)) / 132;
		t  = longint'(ONE_Q30) - longint'(mul_q30(x2, t)) / 90;
		t  = longint'(ONE_Q30) - longint'(mul_q30(x2, t)) / 56;
		t  = longint'(ONE_Q30) - longint'(mul_q30(x2, t)) / 30;
		t  = longint'(ONE_Q30) - longint'(mul_q30(x2, t)) / 12;
		t  = longint'(ONE_Q30) - longint'(mul_q30(x2, t)) / 2;
		if (t < 0) begin
			t = 0;
		end
		if (t > longint'(ONE_Q30)) begin
			t = longint'(ONE_Q30);
		end
		return t;
	endfunction

endpackage

// File: rtl/transverse_mass_calc.sv
// Transverse mass of a lepton and the missing transverse energy, fully pipelined.
//
// The slave stream carries one candidate per beat: lepton pt and azimuth and the
// missing transverse energy and its azimuth. The master stream returns one beat per
// candidate with floor(sqrt(2*pt*met*(1-cos(dphi)))) in the momentum unit.
// A new beat is taken every cycle unless the output stalls. The stages are one
// for the angle fold and pt*met, one for the cosine table, two for the radicand
// product, then one stage per bit of the digit-by-digit square root.
// The whole pipeline holds while a result waits at the output and the receiver
// keeps m_tready low; s_tready then drops, so no beat is lost or repeated.
// Bubbles travel as cleared valid bits.
// Asynchronous reset clears every valid bit; s_tready rises after the first clock
// edge once reset is released. No state is carried between beats.
module transverse_mass_calc
	import tmc_pkg::*;
#(
	parameter int ANGLE_BITS    = DEF_ANGLE_BITS,
	parameter int MOMENTUM_BITS = DEF_MOMENTUM_BITS,
	localparam int IN_W  = ((2 * MOMENTUM_BITS + 2 * ANGLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((MOMENTUM_BITS + 1 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// lep_pt, lep_phi, missing_et, missing_phi
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// trans_mass
	output logic [OUT_W-1:0] m_tdata
);

	localparam int AB      = ANGLE_BITS;
	localparam int MB      = MOMENTUM_BITS;
	localparam int QUARTER = 1 << (AB - 2);
	localparam int HALF    = 1 << (AB - 1);
	localparam int PW      = 2 * MB;
	localparam int HW      = MB + G_W;
	localparam int SW      = 2 * MB + G_W + 1;
	localparam int RB      = MB + 1;
	localparam int VW      = 2 * RB;
	localparam int RW      = RB + 2;

	logic [30:0] cos_tab [QUARTER+1];

	for (genvar i = 0; i <= QUARTER; i++) begin : g_cos
		assign cos_tab[i] = 31'(cos_q30(AB, i));
	end

	logic ce;
	logic in_acc;
	logic rdy_q;

	logic [MB-1:0] pt;
	logic [MB-1:0] met;
	logic [AB-1:0] lphi;
	logic [AB-1:0] mphi;
	logic [AB-1:0] diff;
	logic [AB-1:0] dfold;
	logic          far;

	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PW-1:0] prod_s1, prod_s2;
	logic [AB-2:0] idx_s1;
	logic          far_s1;
	logic [G_W-1:0] g_s2;
	logic [G_W-1:0] cos_ext;
	logic [HW-1:0] hi_s3, lo_s3;
	logic [SW-1:0] sum;
	logic [VW-1:0] mt2_s4;

	logic          sq_vld_s  [RB];
	logic [RW-1:0] sq_rem_s  [RB];
	logic [RB-1:0] sq_root_s [RB];
	logic [VW-1:0] sq_v_s    [RB];

	assign ce       = !sq_vld_s[RB-1] || m_tready;
	assign s_tready = rdy_q && ce;
	assign in_acc   = s_tvalid && s_tready;

	assign pt   = s_tdata[MB-1:0];
	assign lphi = s_tdata[MB +: AB];
	assign met  = s_tdata[MB+AB +: MB];
	assign mphi = s_tdata[2*MB+AB +: AB];

	always_comb begin
		diff  = lphi - mphi;
		dfold = (diff > AB'(HALF)) ? AB'(-diff) : diff;
		far   = dfold > AB'(QUARTER);
	end

	assign cos_ext = G_W'(cos_tab[idx_s1]);
	assign sum     = {hi_s3, MB'(0)} + SW'(lo_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q  <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			rdy_q <= 1'b1;
			if (ce) begin
				vld_s1 <= in_acc;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			prod_s1 <= PW'(pt) * PW'(met);
			far_s1  <= far;
			idx_s1  <= far ? (AB-1)'(AB'(HALF) - dfold) : (AB-1)'(dfold);
			prod_s2 <= prod_s1;
			g_s2    <= far_s1 ? (G_W'(ONE_Q30) + cos_ext) : (G_W'(ONE_Q30) - cos_ext);
			hi_s3   <= HW'(prod_s2[PW-1:MB]) * HW'(g_s2);
			lo_s3   <= HW'(prod_s2[MB-1:0]) * HW'(g_s2);
			mt2_s4  <= sum[29 +: VW];
		end
	end

	for (genvar j = 0; j < RB; j++) begin : g_sqrt
		logic          vin;
		logic [RW-1:0] rin;
		logic [RB-1:0] qin;
		logic [VW-1:0] din;
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign vin = vld_s4;
			assign rin = '0;
			assign qin = '0;
			assign din = mt2_s4;
		end else begin : g_next
			assign vin = sq_vld_s[j-1];
			assign rin = sq_rem_s[j-1];
			assign qin = sq_root_s[j-1];
			assign din = sq_v_s[j-1];
		end

		assign cur   = {rin[RW-3:0], din[VW-1 -: 2]};
		assign trial = {qin, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j] <= 1'b0;
			end else if (ce) begin
				sq_vld_s[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				sq_rem_s[j]  <= ge ? (cur - trial) : cur;
				sq_root_s[j] <= {qin[RB-2:0], ge};
				sq_v_s[j]    <= {din[VW-3:0], 2'b00};
			end
		end
	end

	assign m_tvalid = sq_vld_s[RB-1];
	assign m_tdata  = OUT_W'(sq_root_s[RB-1]);

endmodule

// File: rtl/tmc_checker.sv
// Port-level checker for the transverse mass block and its bind statement.
`include "transverse_mass_calc_macros.svh"

module tmc_checker
	import tmc_pkg::*;
#(
	parameter int MOMENTUM_BITS = DEF_MOMENTUM_BITS,
	localparam int OUT_W = ((MOMENTUM_BITS + 1 + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	// trans_mass
	input logic [OUT_W-1:0] m_tdata
);

	localparam int RB = MOMENTUM_BITS + 1;

	// Once rdy_q is set after reset, the input side only waits while a result is held back by the receiver.
	`TMC_ASSERT_NOW(a_ready_follows_out, s_tvalid && !s_tready, m_tvalid && !m_tready, "input stalled without an output stall")
	// A ready input is never offered while the output beat is stuck.
	`TMC_ASSERT_NOW(a_no_take_when_full, m_tvalid && !m_tready, !s_tready, "input ready while output is stalled")
	`TMC_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid, "output beat dropped while stalled")
	`TMC_ASSERT_NEXT(a_out_data_holds, m_tvalid && !m_tready, $stable(m_tdata), "output beat changed while stalled")
	// The mass never exceeds its field, so the padding stays clear.
	`TMC_ASSERT_NOW(a_out_padding, m_tvalid, (m_tdata >> RB) == '0, "padding bits of the output beat set")

endmodule

bind transverse_mass_calc tmc_checker #(
	.MOMENTUM_BITS(MOMENTUM_BITS)
) u_tmc_checker (.*);
